// ===== hdl/cst_pkg.sv =====
// Package with the scanner modes, token kinds, error codes, sizes and character helper functions.
`default_nettype none
package cst_pkg;
    typedef enum logic [4:0] {
        M_IDLE, M_NAME, M_NZERO, M_NHEX, M_NBIN, M_NOCT, M_NDEC, M_NSUF,
        M_DOT1, M_DOT2, M_OP1, M_OPEQ, M_AMP, M_LDIR, M_LCOM, M_BLOCK,
        M_STR, M_STRESC, M_CH0, M_CHX, M_CHQ
    } t_mode;

    localparam logic [3:0] K_NAME = 4'd0;
    localparam logic [3:0] K_DIRECTIVE = 4'd1;
    localparam logic [3:0] K_COMMENT = 4'd2;
    localparam logic [3:0] K_TYPEDEF = 4'd3;
    localparam logic [3:0] K_STRUCT = 4'd4;
    localparam logic [3:0] K_ENUM = 4'd5;
    localparam logic [3:0] K_BRACKET = 4'd6;
    localparam logic [3:0] K_SEPARATOR = 4'd7;
    localparam logic [3:0] K_OPERATOR = 4'd8;
    localparam logic [3:0] K_ACCESS = 4'd9;
    localparam logic [3:0] K_LITERAL = 4'd10;

    localparam logic [1:0] E_NONE = 2'd0;
    localparam logic [1:0] E_UNKNOWN = 2'd1;
    localparam logic [1:0] E_STRING = 2'd2;
    localparam logic [1:0] E_CHAR = 2'd3;

    localparam int WIN = 7;
    localparam int COL_BITS = 16;
    localparam logic [15:0] COL_MAX = 16'hFFFF;

    function automatic logic is_digit(input logic [7:0] b);
        return b >= "0" && b <= "9";
    endfunction
    function automatic logic is_alpha(input logic [7:0] b);
        return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z");
    endfunction
    function automatic logic [7:0] upper(input logic [7:0] b);
        return (b >= "a" && b <= "z") ? b - 8'd32 : b;
    endfunction
    function automatic logic is_suffix(input logic [7:0] b);
        return upper(b) == "L" || upper(b) == "U" || upper(b) == "F";
    endfunction
endpackage
`default_nettype wire

// ===== hdl/cst_scanner.sv =====
// Scanner state and the per-byte transition that produces up to three token results.
`default_nettype none
module cst_scanner #(
    parameter int LINE_BITS = 24,
    parameter int LENGTH_BITS = 16
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_step,
    input  wire logic [7:0] i_byte,
    input  wire logic i_eoi,
    output logic [1:0] o_count,
    output logic [3:0] o_kind [3],
    output logic [LINE_BITS-1:0] o_line [3],
    output logic [cst_pkg::COL_BITS-1:0] o_col [3],
    output logic [LENGTH_BITS-1:0] o_len [3],
    output logic [1:0] o_err [3]
);
    import cst_pkg::*;

    localparam logic [LINE_BITS-1:0] LMAX = {LINE_BITS{1'b1}};
    localparam logic [LENGTH_BITS-1:0] NMAX = {LENGTH_BITS{1'b1}};

    t_mode r_mode, n_mode;
    logic [LINE_BITS-1:0] r_line, n_line, r_sline, n_sline;
    logic [COL_BITS-1:0] r_col, n_col, r_scol, n_scol;
    logic [LENGTH_BITS-1:0] r_cnt, n_cnt;
    logic [7:0] r_win [WIN];
    logic [7:0] n_win [WIN];
    logic [7:0] r_prev, n_prev;
    logic r_err, n_err;
    logic [1:0] n_count;
    logic [3:0] n_kind [3];
    logic [LINE_BITS-1:0] n_rline [3];
    logic [COL_BITS-1:0] n_rcol [3];
    logic [LENGTH_BITS-1:0] n_rlen [3];
    logic [1:0] n_rerr [3];

    always_comb begin
        logic take, fl, done, ml;
        logic [7:0] b;
        logic [3:0] nk;
        take = 1'b0;
        fl = 1'b0;
        done = 1'b0;
        ml = 1'b0;
        nk = K_NAME;
        b = i_byte;
        n_mode = r_mode;
        n_line = r_line;
        n_col = r_col;
        n_sline = r_sline;
        n_scol = r_scol;
        n_cnt = r_cnt;
        n_win = r_win;
        n_prev = r_prev;
        n_err = r_err;
        n_count = 2'd0;
        for (int k = 0; k < 3; k++) begin
            n_kind[k] = K_NAME;
            n_rline[k] = '0;
            n_rcol[k] = '0;
            n_rlen[k] = '0;
            n_rerr[k] = E_NONE;
        end
        if (!r_err) begin
            if (i_eoi) begin
                fl = 1'b1;
            end else begin
                case (r_mode)
                    M_IDLE: ;
                    M_NAME: begin
                        if (is_alpha(b) || is_digit(b) || b == "_") begin
                            take = 1'b1;
                            for (int k = 0; k < WIN - 1; k++) n_win[k] = r_win[k+1];
                            n_win[WIN-1] = b;
                        end
                    end
                    M_NZERO: begin
                        if (upper(b) == "X") begin
                            take = 1'b1; n_mode = M_NHEX;
                        end else if (upper(b) == "B") begin
                            take = 1'b1; n_mode = M_NBIN;
                        end else if ((b >= "0" && b <= "7") || b == "'") begin
                            take = 1'b1; n_mode = M_NOCT;
                        end else if (is_suffix(b)) begin
                            take = 1'b1; n_mode = M_NSUF;
                        end
                    end
                    M_NHEX, M_NBIN, M_NOCT, M_NDEC: begin
                        if ((r_mode == M_NHEX && (is_digit(b) || b == "'" ||
                                (upper(b) >= "A" && upper(b) <= "F"))) ||
                            (r_mode == M_NBIN && (b == "0" || b == "1" || b == "'")) ||
                            (r_mode == M_NOCT && ((b >= "0" && b <= "7") || b == "'")) ||
                            (r_mode == M_NDEC && (is_digit(b) || b == "'" || b == ".")))
                            take = 1'b1;
                        else if (is_suffix(b)) begin
                            take = 1'b1; n_mode = M_NSUF;
                        end
                    end
                    M_NSUF: take = is_suffix(b);
                    M_DOT1: if (b == ".") begin
                        take = 1'b1; n_mode = M_DOT2;
                    end
                    M_DOT2: if (b == ".") begin
                        take = 1'b1; done = 1'b1; nk = K_NAME;
                    end
                    M_OP1, M_OPEQ: begin
                        if (r_mode == M_OP1 && b == "=") begin
                            take = 1'b1;
                            if (r_prev == "-" || r_prev == "/") n_mode = M_OPEQ;
                            else begin
                                done = 1'b1; nk = K_OPERATOR;
                            end
                        end else if (r_prev == "-" && b == ">") begin
                            take = 1'b1; done = 1'b1; nk = K_ACCESS;
                        end else if (r_prev == "/" && (b == "/" || b == "*")) begin
                            take = 1'b1;
                            if (b == "/") begin
                                n_mode = M_LCOM; n_prev = 8'h0A;
                            end else begin
                                n_mode = M_BLOCK; n_prev = 8'h00;
                            end
                        end
                    end
                    M_AMP: if (b == r_prev || b == "=") begin
                        take = 1'b1; done = 1'b1; nk = K_OPERATOR;
                    end
                    M_LDIR, M_LCOM: begin
                        ml = 1'b1;
                        if (b == 8'h0A) begin
                            n_line = (r_line < LMAX) ? r_line + 1'b1 : r_line;
                            n_col = '0;
                            if (r_prev == "\\") begin
                                n_cnt = (r_cnt < NMAX) ? r_cnt + 1'b1 : r_cnt;
                                n_prev = 8'h0A;
                            end else begin
                                done = 1'b1;
                                nk = (r_mode == M_LDIR) ? K_DIRECTIVE : K_COMMENT;
                            end
                        end else begin
                            n_cnt = (r_cnt < NMAX) ? r_cnt + 1'b1 : r_cnt;
                            n_prev = b;
                        end
                    end
                    M_BLOCK: begin
                        take = 1'b1;
                        if (r_prev == "*" && b == "/") begin
                            done = 1'b1; nk = K_COMMENT;
                        end else n_prev = b;
                    end
                    M_STR: begin
                        take = 1'b1;
                        if (b == "\"") begin
                            done = 1'b1; nk = K_LITERAL;
                        end else if (b == "\\") n_mode = M_STRESC;
                    end
                    M_STRESC: begin
                        take = 1'b1; n_mode = M_STR;
                    end
                    M_CH0: begin
                        take = 1'b1; n_mode = (b == "\\") ? M_CHX : M_CHQ;
                    end
                    M_CHX: begin
                        take = 1'b1; n_mode = M_CHQ;
                    end
                    M_CHQ: begin
                        if (b == "'") begin
                            take = 1'b1; done = 1'b1; nk = K_LITERAL;
                        end else begin
                            ml = 1'b1;
                            n_count = 2'd1;
                            n_rline[0] = r_line;
                            n_rcol[0] = r_col;
                            n_rerr[0] = E_CHAR;
                            n_err = 1'b1;
                            n_mode = M_IDLE;
                        end
                    end
                    default: n_mode = M_IDLE;
                endcase
                if (take) begin
                    n_cnt = (r_cnt < NMAX) ? r_cnt + 1'b1 : r_cnt;
                    if (b == 8'h0A) begin
                        n_line = (r_line < LMAX) ? r_line + 1'b1 : r_line;
                        n_col = '0;
                    end else if (r_col < COL_MAX) n_col = r_col + 1'b1;
                end
                if (done) begin
                    n_count = 2'd1;
                    n_kind[0] = nk;
                    n_rline[0] = r_sline;
                    n_rcol[0] = r_scol;
                    n_rlen[0] = n_cnt;
                    n_mode = M_IDLE;
                end
                if (!take && !ml) fl = 1'b1;
            end
            if (fl) begin
                case (r_mode)
                    M_IDLE: ;
                    M_NAME: begin
                        n_count = 2'd1;
                        n_kind[0] = K_NAME;
                        if (r_cnt == LENGTH_BITS'(7) && r_win[0] == "t" && r_win[1] == "y" &&
                            r_win[2] == "p" && r_win[3] == "e" && r_win[4] == "d" &&
                            r_win[5] == "e" && r_win[6] == "f") n_kind[0] = K_TYPEDEF;
                        else if (r_cnt == LENGTH_BITS'(6) && r_win[1] == "s" &&
                            r_win[2] == "t" && r_win[3] == "r" && r_win[4] == "u" &&
                            r_win[5] == "c" && r_win[6] == "t") n_kind[0] = K_STRUCT;
                        else if (r_cnt == LENGTH_BITS'(4) && r_win[3] == "e" &&
                            r_win[4] == "n" && r_win[5] == "u" && r_win[6] == "m")
                            n_kind[0] = K_ENUM;
                        else if ((r_cnt == LENGTH_BITS'(4) && r_win[3] == "t" &&
                            r_win[4] == "r" && r_win[5] == "u" && r_win[6] == "e") ||
                            (r_cnt == LENGTH_BITS'(5) && r_win[2] == "f" && r_win[3] == "a" &&
                            r_win[4] == "l" && r_win[5] == "s" && r_win[6] == "e"))
                            n_kind[0] = K_LITERAL;
                    end
                    M_NZERO, M_NHEX, M_NBIN, M_NOCT, M_NDEC, M_NSUF: begin
                        n_count = 2'd1; n_kind[0] = K_LITERAL;
                    end
                    M_DOT1: begin
                        n_count = 2'd1; n_kind[0] = K_ACCESS;
                    end
                    M_DOT2: begin
                        n_count = 2'd2;
                        n_kind[0] = K_ACCESS;
                        n_kind[1] = K_ACCESS;
                    end
                    M_OP1, M_OPEQ, M_AMP: begin
                        n_count = 2'd1; n_kind[0] = K_OPERATOR;
                    end
                    M_LDIR, M_LCOM: begin
                        n_count = 2'd1;
                        n_kind[0] = (r_mode == M_LDIR) ? K_DIRECTIVE : K_COMMENT;
                    end
                    M_BLOCK: begin
                        n_count = 2'd1; n_kind[0] = K_COMMENT;
                    end
                    default: ;
                endcase
                n_rline[0] = r_sline;
                n_rcol[0] = r_scol;
                n_rlen[0] = r_cnt;
                if ((r_mode == M_LDIR || r_mode == M_LCOM) && r_prev == "\\" && r_cnt < NMAX)
                    n_rlen[0] = r_cnt + 1'b1;
                if (r_mode == M_DOT2) begin
                    n_rlen[0] = LENGTH_BITS'(1);
                    n_rlen[1] = LENGTH_BITS'(1);
                    n_rline[1] = r_sline;
                    n_rcol[1] = (r_scol < COL_MAX) ? r_scol + 1'b1 : r_scol;
                end
                if (r_mode == M_STR || r_mode == M_STRESC || r_mode == M_CH0 ||
                    r_mode == M_CHX || r_mode == M_CHQ) begin
                    n_count = 2'd1;
                    n_rline[0] = r_line;
                    n_rcol[0] = r_col;
                    n_rlen[0] = '0;
                    n_rerr[0] = (r_mode == M_STR || r_mode == M_STRESC) ? E_STRING : E_CHAR;
                    n_err = 1'b1;
                end
                n_mode = M_IDLE;
                if (i_eoi) begin
                    if (!n_err) begin
                        n_line = '0;
                        n_col = '0;
                    end
                end else begin
                    n_sline = r_line;
                    n_scol = r_col;
                    if (b == " " || b == 8'h09 || b == 8'h0B || b == 8'h0C || b == 8'h0D) begin
                        if (r_col < COL_MAX) n_col = r_col + 1'b1;
                    end else if (b == 8'h0A) begin
                        n_line = (r_line < LMAX) ? r_line + 1'b1 : r_line;
                        n_col = '0;
                    end else if (is_alpha(b) || b == "_" || is_digit(b) || b == "(" ||
                        b == ")" || b == "[" || b == "]" || b == "{" || b == "}" ||
                        b == ";" || b == "," || b == ":" || b == "?" || b == "." ||
                        b == "=" || b == "+" || b == "-" || b == "*" || b == "/" ||
                        b == "!" || b == "^" || b == ">" || b == "<" || b == "&" ||
                        b == "|" || b == "'" || b == "\"" || b == "#") begin
                        n_cnt = LENGTH_BITS'(1);
                        if (r_col < COL_MAX) n_col = r_col + 1'b1;
                        if (is_alpha(b) || b == "_") begin
                            n_mode = M_NAME;
                            for (int k = 0; k < WIN - 1; k++) n_win[k] = 8'h00;
                            n_win[WIN-1] = b;
                        end else if (is_digit(b)) n_mode = (b == "0") ? M_NZERO : M_NDEC;
                        else if (b == ".") n_mode = M_DOT1;
                        else if (b == "'") n_mode = M_CH0;
                        else if (b == "\"") n_mode = M_STR;
                        else if (b == "#") begin
                            n_mode = M_LDIR; n_prev = 8'h0A;
                        end else if (b == "&" || b == "|") begin
                            n_mode = M_AMP; n_prev = b;
                        end else if (b == "(" || b == ")" || b == "[" || b == "]" ||
                            b == "{" || b == "}" || b == ";" || b == "," || b == ":" ||
                            b == "?") begin
                            n_kind[n_count] = (b == ";" || b == "," || b == ":" || b == "?")
                                ? K_SEPARATOR : K_BRACKET;
                            n_rline[n_count] = r_line;
                            n_rcol[n_count] = r_col;
                            n_rlen[n_count] = LENGTH_BITS'(1);
                            n_count = n_count + 2'd1;
                        end else begin
                            n_mode = M_OP1; n_prev = b;
                        end
                    end else begin
                        n_rline[n_count] = r_line;
                        n_rcol[n_count] = r_col;
                        n_rlen[n_count] = '0;
                        n_kind[n_count] = K_NAME;
                        n_rerr[n_count] = E_UNKNOWN;
                        n_count = n_count + 2'd1;
                        n_err = 1'b1;
                        n_mode = M_IDLE;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= M_IDLE;
            r_line <= '0;
            r_col <= '0;
            r_sline <= '0;
            r_scol <= '0;
            r_cnt <= '0;
            for (int k = 0; k < WIN; k++) r_win[k] <= 8'h00;
            r_prev <= 8'h00;
            r_err <= 1'b0;
        end else if (i_step) begin
            r_mode <= n_mode;
            r_line <= n_line;
            r_col <= n_col;
            r_sline <= n_sline;
            r_scol <= n_scol;
            r_cnt <= n_cnt;
            r_win <= n_win;
            r_prev <= n_prev;
            r_err <= n_err;
        end
    end

    assign o_count = n_count;
    assign o_kind = n_kind;
    assign o_line = n_rline;
    assign o_col = n_rcol;
    assign o_len = n_rlen;
    assign o_err = n_rerr;
endmodule
`default_nettype wire

// ===== hdl/c_source_tokenizer.sv =====
// Top level: input register, byte scanner and result queue with the stream ports.
`default_nettype none
// The tokenizer accepts one source byte per cycle while ready and emits the tokens it
// finishes; each byte's work is a single registered state transition. A byte's results
// pass through the input register and the result queue before they are offered on the
// output, and a byte can produce up to three results, drained one per cycle while the
// receiver is ready from an eight-entry result queue. Input is ready while at most two
// results wait, so that the queue has room for the worst case of the byte in the input
// register and the byte being accepted; ordinary text runs at one byte per cycle while
// the output is taken. After an error result the block drops all input until reset.
module c_source_tokenizer #(
    parameter int LINE_BITS = 24,
    parameter int LENGTH_BITS = 16
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic s_axis_tvalid,
    output logic s_axis_tready,
    input  wire logic [7:0] s_axis_tdata,  // source_byte
    input  wire logic s_axis_tuser,        // end_of_input
    output logic m_axis_tvalid,
    input  wire logic m_axis_tready,
    // token_kind, start_line, start_column, token_length, error_code, zero fill
    output logic [((4+LINE_BITS+16+LENGTH_BITS+2+7)/8)*8-1:0] m_axis_tdata,
    output logic m_axis_tlast              // last_of_run
);
    import cst_pkg::*;

    localparam int RW = 4 + LINE_BITS + COL_BITS + LENGTH_BITS + 2 + 1;
    localparam int TW = ((RW - 1 + 7) / 8) * 8;
    localparam int QD = 8;

    logic r_iv;
    logic [7:0] r_ib;
    logic r_ie;
    logic [1:0] w_count;
    logic [3:0] w_kind [3];
    logic [LINE_BITS-1:0] w_line [3];
    logic [COL_BITS-1:0] w_col [3];
    logic [LENGTH_BITS-1:0] w_len [3];
    logic [1:0] w_err [3];
    logic [RW-1:0] r_q [QD];
    logic [2:0] r_wp, r_rp;
    logic [3:0] r_fill;
    logic w_pop;
    logic [3:0] w_room;

    cst_scanner #(.LINE_BITS(LINE_BITS), .LENGTH_BITS(LENGTH_BITS)) u_scan (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_step(r_iv),
        .i_byte(r_ib), .i_eoi(r_ie), .o_count(w_count), .o_kind(w_kind),
        .o_line(w_line), .o_col(w_col), .o_len(w_len), .o_err(w_err)
    );

    // Room must cover the byte held in the input register and the one being taken.
    assign w_room = 4'(QD) - r_fill;
    assign s_axis_tready = (w_room >= 4'd6);
    assign w_pop = m_axis_tvalid && m_axis_tready;
    assign m_axis_tvalid = (r_fill != 4'd0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_iv <= 1'b0;
        end else begin
            r_iv <= s_axis_tvalid && s_axis_tready;
        end
        r_ib <= s_axis_tdata;
        r_ie <= s_axis_tuser;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0;
            r_rp <= '0;
            r_fill <= '0;
        end else begin
            if (r_iv) begin
                for (int k = 0; k < 3; k++) begin
                    if (2'(k) < w_count) begin
                        r_q[3'(r_wp + 3'(k))] <= {(2'(k + 1) == w_count), w_err[k],
                            w_len[k], w_col[k], w_line[k], w_kind[k]};
                    end
                end
                r_wp <= r_wp + 3'(w_count);
            end
            if (w_pop) r_rp <= r_rp + 3'd1;
            r_fill <= r_fill + (r_iv ? 4'(w_count) : 4'd0) - (w_pop ? 4'd1 : 4'd0);
        end
    end

    assign m_axis_tdata = TW'(r_q[r_rp][RW-2:0]);
    assign m_axis_tlast = r_q[r_rp][RW-1];

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= 4'(QD)) else $error("result queue overflow");
    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_fill == 4'd0) |-> !m_axis_tvalid) else $error("valid with empty queue");
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_iv |-> (w_count <= 2'd3)) else $error("too many results");
endmodule
`default_nettype wire
